// File: sv/bfpa_pkg.sv
// bfpa_pkg: shared types and constants for the best-fit partition allocator
// no dependencies; used by the channel interfaces, the cell and the top level
`default_nettype none

package bfpa_pkg;

	localparam int NUM_PARTS_DEF = 16;
	localparam int SIZE_BITS_DEF = 16;

	localparam int CMD_W  = 1;
	localparam int PIDX_W = 4;
	localparam int AMT_W  = 16;

	localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
	localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

	// search token control travelling along the cell row
	typedef struct packed {
		logic valid;
		logic found;
	} bfpa_tok_t;

	// table updates broadcast to every cell
	typedef struct packed {
		logic load;
		logic commit;
	} bfpa_wr_t;

	typedef struct packed {
		logic              granted;
		logic [PIDX_W-1:0] index;
		logic [AMT_W-1:0]  size;
	} bfpa_res_t;

endpackage

`default_nettype wire

// File: sv/bfpa_if.sv
// bfpa_in_if, bfpa_out_if: valid/ready channels of the partition allocator
// depends on bfpa_pkg for field widths
`default_nettype none

interface bfpa_in_if;
	import bfpa_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [PIDX_W-1:0] part_index;
	logic [AMT_W-1:0]  amount;

	modport source (output valid, output cmd, output part_index, output amount, input ready);
	modport sink   (input valid, input cmd, input part_index, input amount, output ready);
endinterface

interface bfpa_out_if;
	import bfpa_pkg::*;

	logic              valid;
	logic              ready;
	logic              granted;
	logic [PIDX_W-1:0] granted_index;
	logic [AMT_W-1:0]  granted_size;

	modport source (output valid, output granted, output granted_index, output granted_size,
		input ready);
	modport sink   (input valid, input granted, input granted_index, input granted_size,
		output ready);
endinterface

`default_nettype wire

// File: sv/bfpa_cell.sv
// bfpa_cell: one partition entry plus one stage of the best-fit search row
// depends on bfpa_pkg
`default_nettype none

module bfpa_cell #(
	parameter int NUM_PARTS = bfpa_pkg::NUM_PARTS_DEF,
	parameter int SIZE_BITS = bfpa_pkg::SIZE_BITS_DEF,
	parameter int CELL_IDX  = 0,
	parameter int IDX_W     = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire bfpa_pkg::bfpa_wr_t              wr,
	input  wire logic [bfpa_pkg::PIDX_W-1:0]     ld_idx,
	input  wire logic [SIZE_BITS-1:0]            ld_size,
	input  wire logic [IDX_W-1:0]                cm_idx,
	input  wire bfpa_pkg::bfpa_tok_t             tok_in,
	input  wire logic [bfpa_pkg::AMT_W-1:0]      amt_in,
	input  wire logic [IDX_W-1:0]                idx_in,
	input  wire logic [SIZE_BITS-1:0]            size_in,
	output bfpa_pkg::bfpa_tok_t                  tok_out,
	output logic [bfpa_pkg::AMT_W-1:0]           amt_out,
	output logic [IDX_W-1:0]                     idx_out,
	output logic [SIZE_BITS-1:0]                 size_out
);
	import bfpa_pkg::*;

	localparam int CMP_W = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

	logic [SIZE_BITS-1:0] size_q;
	logic                 in_use_q;
	bfpa_tok_t            tok_q;
	logic [AMT_W-1:0]     amt_q;
	logic [IDX_W-1:0]     idx_q;
	logic [SIZE_BITS-1:0] bsize_q;
	logic                 ld_hit;
	logic                 cm_hit;
	logic                 better;

	assign ld_hit = wr.load && (32'(ld_idx) == CELL_IDX);
	assign cm_hit = wr.commit && (32'(cm_idx) == CELL_IDX);

	assign better = !in_use_q && (CMP_W'(size_q) >= CMP_W'(amt_in)) &&
		(!tok_in.found || (size_q < size_in));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= 1'b1;
			tok_q    <= '0;
		end else begin
			if (ld_hit) begin
				in_use_q <= 1'b0;
			end else if (cm_hit) begin
				in_use_q <= 1'b1;
			end
			tok_q.valid <= tok_in.valid;
			tok_q.found <= tok_in.found || better;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_hit) begin
			size_q <= ld_size;
		end
		amt_q <= amt_in;
		if (better) begin
			idx_q   <= IDX_W'(CELL_IDX);
			bsize_q <= size_q;
		end else begin
			idx_q   <= idx_in;
			bsize_q <= size_in;
		end
	end

	assign tok_out  = tok_q;
	assign amt_out  = amt_q;
	assign idx_out  = idx_q;
	assign size_out = bsize_q;

endmodule

`default_nettype wire

// File: sv/best_fit_partition_allocator.sv
// best_fit_partition_allocator: best-fit allocator over a row of partition cells
// depends on bfpa_pkg, bfpa_if (bfpa_in_if, bfpa_out_if) and bfpa_cell
//
//  channel  | dir | fields
//  in_ch    | in  | cmd, part_index, amount
//  out_ch   | out | granted, granted_index, granted_size (one per allocate)
//
// a load is written into its cell when taken and gives no result
// an allocate walks the cell row, one cell per cycle, and its result is registered into the output or hold register
// one result may wait in the output register and one more in a hold register
// no new item is taken while a search is in the row or the hold register is full
// after reset every partition is unavailable until loaded
`default_nettype none

module best_fit_partition_allocator #(
	parameter int NUM_PARTS = bfpa_pkg::NUM_PARTS_DEF,
	parameter int SIZE_BITS = bfpa_pkg::SIZE_BITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	bfpa_in_if.sink     in_ch,
	bfpa_out_if.source  out_ch
);
	import bfpa_pkg::*;

	localparam int IDX_W = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;

	bfpa_tok_t            tok   [NUM_PARTS+1];
	logic [AMT_W-1:0]     amt   [NUM_PARTS+1];
	logic [IDX_W-1:0]     bidx  [NUM_PARTS+1];
	logic [SIZE_BITS-1:0] bsize [NUM_PARTS+1];
	logic [NUM_PARTS:0]   tok_vld;

	bfpa_wr_t             wr;
	logic                 in_xfer;
	logic                 out_xfer;
	logic                 tail;
	bfpa_res_t            tail_res;

	logic                 scan_busy_q;
	logic                 out_vld_q;
	logic                 pend_q;
	bfpa_res_t            out_q;
	bfpa_res_t            pend_res_q;

	assign in_ch.ready = !scan_busy_q && !pend_q;
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign out_xfer    = out_vld_q && out_ch.ready;
	assign tail        = tok[NUM_PARTS].valid;

	assign tok[0].valid = in_xfer && (in_ch.cmd == CMD_ALLOC);
	assign tok[0].found = 1'b0;
	assign amt[0]       = in_ch.amount;
	assign bidx[0]      = '0;
	assign bsize[0]     = '0;

	assign wr.load   = in_xfer && (in_ch.cmd == CMD_LOAD);
	assign wr.commit = tail && tok[NUM_PARTS].found;

	genvar k;
	generate
		for (k = 0; k <= NUM_PARTS; k++) begin : g_vld
			assign tok_vld[k] = tok[k].valid;
		end
		for (k = 0; k < NUM_PARTS; k++) begin : g_cell
			bfpa_cell #(
				.NUM_PARTS (NUM_PARTS),
				.SIZE_BITS (SIZE_BITS),
				.CELL_IDX  (k),
				.IDX_W     (IDX_W)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.wr       (wr),
				.ld_idx   (in_ch.part_index),
				.ld_size  (SIZE_BITS'(in_ch.amount)),
				.cm_idx   (bidx[NUM_PARTS]),
				.tok_in   (tok[k]),
				.amt_in   (amt[k]),
				.idx_in   (bidx[k]),
				.size_in  (bsize[k]),
				.tok_out  (tok[k+1]),
				.amt_out  (amt[k+1]),
				.idx_out  (bidx[k+1]),
				.size_out (bsize[k+1])
			);
		end
	endgenerate

	always_comb begin
		tail_res.granted = tok[NUM_PARTS].found;
		tail_res.index   = tok[NUM_PARTS].found ? PIDX_W'(bidx[NUM_PARTS]) : '0;
		tail_res.size    = tok[NUM_PARTS].found ? AMT_W'(bsize[NUM_PARTS]) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_busy_q <= 1'b0;
			out_vld_q   <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			if (tok[0].valid) begin
				scan_busy_q <= 1'b1;
			end else if (tail) begin
				scan_busy_q <= 1'b0;
			end
			if (tail) begin
				if (!out_vld_q || out_xfer) begin
					out_vld_q <= 1'b1;
				end else begin
					pend_q <= 1'b1;
				end
			end else if (out_xfer) begin
				if (pend_q) begin
					pend_q <= 1'b0;
				end else begin
					out_vld_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail) begin
			if (!out_vld_q || out_xfer) begin
				out_q <= tail_res;
			end else begin
				pend_res_q <= tail_res;
			end
		end else if (out_xfer && pend_q) begin
			out_q <= pend_res_q;
		end
	end

	assign out_ch.valid         = out_vld_q;
	assign out_ch.granted       = out_q.granted;
	assign out_ch.granted_index = out_q.index;
	assign out_ch.granted_size  = out_q.size;

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_vld) <= 1)
		else $error("more than one search token in the cell row");

	a_tail_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tail |-> scan_busy_q)
		else $error("search result without a running search");

	a_pend_full: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> out_vld_q)
		else $error("hold register full while output register empty");

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tok[0].valid |-> !scan_busy_q && !pend_q)
		else $error("search started while busy");

endmodule

`default_nettype wire
